### rtl/tcfb_pkg.sv
// ----------------------------------------------------------------------------
// Text cell framebuffer package
// Command, result and state codes, and the 5x8 font used to draw cells.
// ----------------------------------------------------------------------------
package tcfb_pkg;

    // Command codes of the input channel.
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_PUT   = 3'd2;
    localparam logic [2:0] CMD_ENDL  = 3'd3;
    localparam logic [2:0] CMD_FLUSH = 3'd4;

    // Result kinds of the output channel.
    localparam logic [1:0] KIND_ACK       = 2'd0;
    localparam logic [1:0] KIND_PAGE_ADDR = 2'd1;
    localparam logic [1:0] KIND_DATA      = 2'd2;
    localparam logic [1:0] KIND_NONE      = 2'd3;

    // Printable range of the font and the page address command base.
    localparam logic [7:0] CHAR_FIRST     = 8'h20;
    localparam logic [7:0] CHAR_LAST      = 8'h7E;
    localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;

    // One memory word holds eight column bytes.
    localparam int WORD_BITS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_ACK,
        ST_FLUSH_ADDR,
        ST_FLUSH_DATA
    } t_state;

    // Eight column bytes of a cell; byte 0 is the leftmost column.
    typedef logic [7:0][7:0] t_cell;

    // Font: five column bytes per printable character, bit 0 is the top row.
    localparam logic [7:0] GLYPHS [95][5] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h10,8'h08,8'h08,8'h10,8'h08}
    };

    // Cell bytes for a character code; unprintable codes give a space.
    // Columns five to seven are the blank gap.
    function automatic t_cell cell_of(input logic [7:0] code);
        t_cell      glyph_bytes;
        logic [6:0] idx;
        glyph_bytes = '0;
        if (code < CHAR_FIRST || code > CHAR_LAST) begin
            idx = 7'd0;
        end else begin
            idx = 7'(code - CHAR_FIRST);
        end
        for (int i = 0; i < 5; i++) begin
            glyph_bytes[i] = GLYPHS[idx][i];
        end
        return glyph_bytes;
    endfunction

endpackage

### rtl/tcfb_ram.sv
// ----------------------------------------------------------------------------
// Text cell framebuffer RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcfb_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_cell_framebuffer_dirty_pages.sv
// ----------------------------------------------------------------------------
// Text cell framebuffer with dirty page tracking
// Draws 5x8 text cells into a page organized 1-bit framebuffer and flushes
// the lowest dirty page as a page address followed by 64-bit column words.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the i_valid / o_ready channel (clear, start line, put
// char, end line, flush page); results leave on o_valid / i_ready, one
// transfer per result, with o_last on the final result of each command.
// The store is held as 64-bit words of eight columns in one RAM with a
// registered read; writes are read-modify-write, one word a cycle.
// Steps per command:
//   clear, start line, unknown codes: accept, then the acknowledge.
//   put char: 1 or 2 words rewritten, then the acknowledge.
//   end line: each word from the cursor to the row end rewritten, then the acknowledge.
//   flush: page address, then (WIDTH+7)/8 data words, one per cycle while the
//   receiver is ready; the single read port sets that pace.
// A new command is taken only after the last result of the previous one is
// in the output register. When the receiver stalls, the output register holds
// its result and the sequencer waits. Reset clears the per-word nonzero flags,
// which stand for an all-zero store, the dirty bits and the cursor; no clearing
// pass runs, so a command is taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module text_cell_framebuffer_dirty_pages #(
    parameter int PAGES      = 8,
    parameter int WIDTH      = 128,
    parameter int CELL_WIDTH = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_row,
    input  logic [6:0]  i_column,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_page,
    output logic [63:0] o_data,
    output logic        o_changed,
    output logic        o_accepted,
    output logic        o_last
);

    localparam int WORDS = (WIDTH + 7) / 8;
    localparam int WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PI    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int DEPTH = PAGES << WB;
    localparam int AW    = $clog2(DEPTH);
    localparam int NZW   = $clog2(DEPTH + 1);

    tcfb_pkg::t_state r_state, n_state;

    logic [2:0]       r_cursor_row;
    logic [7:0]       r_cursor_col;
    logic [PAGES-1:0] r_dirty;
    logic [DEPTH-1:0] r_nz;
    logic [NZW-1:0]   r_nz_count, n_nz_count;
    logic [2:0]       r_page, n_page;
    logic [WB-1:0]    r_word, n_word;
    logic [WB-1:0]    r_last_word;
    logic [7:0]       r_lo, r_hi;
    tcfb_pkg::t_cell  r_glyph;
    logic             r_changed, r_accepted;
    logic [1:0]       r_ack_kind;

    logic             r_out_valid;
    logic [1:0]       r_kind, n_kind;
    logic [2:0]       r_opage, n_opage;
    logic [63:0]      r_odata, n_odata;
    logic             r_ochanged, n_ochanged;
    logic             r_oaccepted, n_oaccepted;
    logic             r_olast, n_olast;

    logic             accept, advance, out_load, ram_we;
    logic             row_ok, char_ok, line_ok, any_dirty, rmw_done, flush_end;
    logic [2:0]       low_page;
    logic [8:0]       cell_end;
    logic [AW-1:0]    cur_addr, rd_addr;
    logic [63:0]      ram_q;
    tcfb_pkg::t_cell  old_word, new_word;
    logic             word_changed, old_nz, new_nz;

    // Handshake strobes.
    assign accept  = i_valid && o_ready;
    assign advance = !r_out_valid || i_ready;

    // Command checks against the cursor.
    assign row_ok    = ({1'b0, r_cursor_row} < 4'(PAGES));
    assign cell_end  = {1'b0, r_cursor_col} + 9'(CELL_WIDTH);
    assign char_ok   = row_ok && (cell_end <= 9'(WIDTH));
    assign line_ok   = row_ok && ({1'b0, r_cursor_col} < 9'(WIDTH));
    assign rmw_done  = (r_word == r_last_word);
    assign flush_end = (r_word == WB'(WORDS - 1));

    // Lowest dirty page.
    always_comb begin
        low_page  = 3'd0;
        any_dirty = |r_dirty;
        for (int p = PAGES - 1; p >= 0; p--) begin
            if (r_dirty[p]) begin
                low_page = 3'(p);
            end
        end
    end

    // Word address of the next cycle; the RAM then shows that word's data.
    always_comb begin
        n_page = r_page;
        n_word = r_word;
        unique case (r_state)
            tcfb_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((i_command == tcfb_pkg::CMD_PUT && char_ok) ||
                        (i_command == tcfb_pkg::CMD_ENDL && line_ok)) begin
                        n_page = r_cursor_row;
                        n_word = r_cursor_col[WB+2:3];
                    end else if (i_command == tcfb_pkg::CMD_FLUSH && any_dirty) begin
                        n_page = low_page;
                        n_word = '0;
                    end
                end
            end
            tcfb_pkg::ST_RMW: begin
                n_word = WB'(r_word + 1'b1);
            end
            tcfb_pkg::ST_FLUSH_DATA: begin
                if (advance) begin
                    n_word = WB'(r_word + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    assign cur_addr = AW'({r_page, r_word});
    assign rd_addr  = AW'({n_page, n_word});

    tcfb_ram #(
        .DATA_W (tcfb_pkg::WORD_BITS),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_addr),
        .i_wdata (new_word),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // A word whose nonzero flag is clear reads as zero.
    assign old_nz   = r_nz[cur_addr];
    assign old_word = old_nz ? ram_q : '0;

    // Merge the cell or the blank run into the current word.
    always_comb begin
        logic [7:0] col;
        logic [7:0] off;
        new_word = old_word;
        for (int b = 0; b < 8; b++) begin
            col = 8'({r_word, 3'(b)});
            off = col - r_lo;
            if (col >= r_lo && col < r_hi) begin
                new_word[b] = r_glyph[off[2:0]];
            end
        end
    end

    assign word_changed = (new_word != old_word);
    assign new_nz       = (new_word != '0);

    always_comb begin
        n_nz_count = r_nz_count;
        if (new_nz && !old_nz) begin
            n_nz_count = NZW'(r_nz_count + 1'b1);
        end else if (!new_nz && old_nz) begin
            n_nz_count = NZW'(r_nz_count - 1'b1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcfb_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        tcfb_pkg::CMD_PUT:   n_state = char_ok ? tcfb_pkg::ST_RMW
                                                               : tcfb_pkg::ST_ACK;
                        tcfb_pkg::CMD_ENDL:  n_state = line_ok ? tcfb_pkg::ST_RMW
                                                               : tcfb_pkg::ST_ACK;
                        tcfb_pkg::CMD_FLUSH: n_state = any_dirty ? tcfb_pkg::ST_FLUSH_ADDR
                                                                 : tcfb_pkg::ST_ACK;
                        default:             n_state = tcfb_pkg::ST_ACK;
                    endcase
                end
            end
            tcfb_pkg::ST_RMW: begin
                if (rmw_done) begin
                    n_state = tcfb_pkg::ST_ACK;
                end
            end
            tcfb_pkg::ST_ACK: begin
                if (advance) begin
                    n_state = tcfb_pkg::ST_IDLE;
                end
            end
            tcfb_pkg::ST_FLUSH_ADDR: begin
                if (advance) begin
                    n_state = tcfb_pkg::ST_FLUSH_DATA;
                end
            end
            tcfb_pkg::ST_FLUSH_DATA: begin
                if (advance && flush_end) begin
                    n_state = tcfb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcfb_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, RAM write and the next result.
    always_comb begin
        o_ready     = 1'b0;
        ram_we      = 1'b0;
        out_load    = 1'b0;
        n_kind      = tcfb_pkg::KIND_ACK;
        n_opage     = 3'd0;
        n_odata     = '0;
        n_ochanged  = 1'b0;
        n_oaccepted = 1'b0;
        n_olast     = 1'b1;
        unique case (r_state)
            tcfb_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            tcfb_pkg::ST_RMW: begin
                ram_we = 1'b1;
            end
            tcfb_pkg::ST_ACK: begin
                out_load    = advance;
                n_kind      = r_ack_kind;
                n_ochanged  = r_changed;
                n_oaccepted = r_accepted;
            end
            tcfb_pkg::ST_FLUSH_ADDR: begin
                out_load = advance;
                n_kind   = tcfb_pkg::KIND_PAGE_ADDR;
                n_opage  = r_page;
                n_odata  = 64'(tcfb_pkg::PAGE_ADDR_BASE | {5'd0, r_page});
                n_olast  = 1'b0;
            end
            tcfb_pkg::ST_FLUSH_DATA: begin
                out_load = advance;
                n_kind   = tcfb_pkg::KIND_DATA;
                n_opage  = r_page;
                n_odata  = old_word;
                n_olast  = flush_end;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcfb_pkg::ST_IDLE;
            r_cursor_row <= '0;
            r_cursor_col <= '0;
            r_dirty      <= '0;
            r_nz         <= '0;
            r_nz_count   <= '0;
            r_page       <= '0;
            r_word       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_page  <= n_page;
            r_word  <= n_word;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                unique case (i_command)
                    tcfb_pkg::CMD_CLEAR: begin
                        r_nz       <= '0;
                        r_nz_count <= '0;
                        r_dirty    <= '1;
                    end
                    tcfb_pkg::CMD_START: begin
                        r_cursor_row <= i_row;
                        r_cursor_col <= {1'b0, i_column};
                    end
                    tcfb_pkg::CMD_PUT: begin
                        if (char_ok) begin
                            r_cursor_col <= cell_end[7:0];
                        end
                    end
                    tcfb_pkg::CMD_FLUSH: begin
                        if (any_dirty) begin
                            r_dirty[low_page[PI-1:0]] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // Write-back bookkeeping of the read-modify-write walk.
            if (ram_we) begin
                r_nz[cur_addr] <= new_nz;
                r_nz_count     <= n_nz_count;
                if (word_changed) begin
                    r_dirty[r_page[PI-1:0]] <= 1'b1;
                end
            end
        end
    end

    // Command context and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_changed  <= (i_command == tcfb_pkg::CMD_CLEAR) && (r_nz_count != '0);
            r_accepted <= (i_command == tcfb_pkg::CMD_PUT) && char_ok;
            r_ack_kind <= (i_command == tcfb_pkg::CMD_FLUSH) ? tcfb_pkg::KIND_NONE
                                                             : tcfb_pkg::KIND_ACK;
            r_lo       <= r_cursor_col;
            if (i_command == tcfb_pkg::CMD_PUT) begin
                r_hi        <= cell_end[7:0];
                r_last_word <= WB'((cell_end - 9'd1) >> 3);
                r_glyph     <= tcfb_pkg::cell_of(i_character);
            end else begin
                r_hi        <= 8'(WIDTH);
                r_last_word <= WB'(WORDS - 1);
                r_glyph     <= '0;
            end
        end else if (ram_we && word_changed) begin
            r_changed <= 1'b1;
        end
        if (out_load) begin
            r_kind      <= n_kind;
            r_opage     <= n_opage;
            r_odata     <= n_odata;
            r_ochanged  <= n_ochanged;
            r_oaccepted <= n_oaccepted;
            r_olast     <= n_olast;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_page     = r_opage;
    assign o_data     = r_odata;
    assign o_changed  = r_ochanged;
    assign o_accepted = r_oaccepted;
    assign o_last     = r_olast;

    // The nonzero word count tracks the flags it summarizes.
    a_nz_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_nz) == 32'(r_nz_count))
        else $error("nonzero word count out of step with flags");

    // The walk never passes its last word.
    a_rmw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcfb_pkg::ST_RMW) |-> (r_word <= r_last_word))
        else $error("read-modify-write walk past its last word");

    // Only flush results may leave without the last flag.
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |->
            (o_kind == tcfb_pkg::KIND_PAGE_ADDR || o_kind == tcfb_pkg::KIND_DATA))
        else $error("non-final result of a command that gives one result");

    // A flush cleans the page that it sends.
    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == tcfb_pkg::CMD_FLUSH && any_dirty) |=>
            !r_dirty[$past(low_page[PI-1:0])])
        else $error("flushed page still dirty");

    // A data word is loaded whenever the flush walk advances.
    a_flush_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcfb_pkg::ST_FLUSH_DATA && advance) |=>
            (r_out_valid && r_kind == tcfb_pkg::KIND_DATA))
        else $error("flush word not loaded into the output register");

endmodule
